// ----- hw/rtl/ldcr_pkg.sv -----
// Shared types, codes and constants for the link deframer with command retry.
// Used by every module of the block; depends on nothing.
package ldcr_pkg;

  localparam int unsigned CHECK_LEN   = 12;
  localparam int unsigned RESP_MAX    = 4;
  localparam int unsigned CFG_INDEX_W = 4;
  localparam int unsigned QUEUE_DEPTH = 4;

  localparam logic [7:0] MAX_RETRIES_RESET = 8'd3;

  localparam logic [1:0] OP_BYTE = 2'd0;
  localparam logic [1:0] OP_TICK = 2'd1;
  localparam logic [1:0] OP_CMD  = 2'd2;

  localparam logic [CFG_INDEX_W-1:0] REG_HEADER      = 4'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_RESP0       = 4'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_RESP1       = 4'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_RESP2       = 4'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_RESP3       = 4'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_RESP_COUNT  = 4'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_PING_ENABLE = 4'd6;
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_RETRIES = 4'd7;

  typedef enum logic [2:0] {
    KIND_PKT_BYTE   = 3'd0,
    KIND_PKT_GOOD   = 3'd1,
    KIND_PKT_BAD    = 3'd2,
    KIND_RESPONSE   = 3'd3,
    KIND_UNKNOWN    = 3'd4,
    KIND_SEND_CMD   = 3'd5,
    KIND_CMD_FAILED = 3'd6,
    KIND_PING       = 3'd7
  } ldcr_kind_e;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] rx_byte;
    logic [7:0] command_code;
    logic       port_open;
  } ldcr_item_t;

  typedef struct packed {
    ldcr_kind_e  kind;
    logic [7:0]  byte_value;
    logic [1:0]  response_index;
    logic [63:0] window_bytes;
    logic [7:0]  command_out;
    logic        last;
  } ldcr_result_t;

  typedef struct packed {
    logic [63:0]                 header_word;
    logic [RESP_MAX-1:0][63:0]   response_word;
    logic [2:0]                  response_count;
    logic                        ping_enable;
    logic [7:0]                  max_retries;
  } ldcr_cfg_t;

  typedef struct packed {
    logic         res_valid;
    ldcr_result_t res;
    logic         resp_hit;
  } ldcr_defr_out_t;

  typedef struct packed {
    logic [1:0]   res_count;
    ldcr_result_t res0;
    ldcr_result_t res1;
  } ldcr_cmd_out_t;

  function automatic logic [7:0] nibble_swap(input logic [7:0] b);
    return {b[3:0], b[7:4]};
  endfunction

endpackage

// ----- hw/rtl/ldcr_chan_if.sv -----
// Valid/ready channel carrying one payload per transaction.
// Generic over the payload type; depends on nothing.
interface ldcr_chan_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source(output valid, output payload, input ready);
  modport sink(input valid, input payload, output ready);
endinterface

// ----- hw/rtl/ldcr_cfg_regs.sv -----
// Configuration register file written through a plain write port.
// Depends on ldcr_pkg for the register indexes and the configuration struct.
module ldcr_cfg_regs
  import ldcr_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write_en,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [63:0]            cfg_data,
  output ldcr_cfg_t              cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.header_word    <= '0;
      cfg.response_word  <= '0;
      cfg.response_count <= '0;
      cfg.ping_enable    <= 1'b0;
      cfg.max_retries    <= MAX_RETRIES_RESET;
    end else if (cfg_write_en) begin
      case (cfg_index)
        REG_HEADER:      cfg.header_word      <= cfg_data;
        REG_RESP0:       cfg.response_word[0] <= cfg_data;
        REG_RESP1:       cfg.response_word[1] <= cfg_data;
        REG_RESP2:       cfg.response_word[2] <= cfg_data;
        REG_RESP3:       cfg.response_word[3] <= cfg_data;
        REG_RESP_COUNT:  cfg.response_count   <= cfg_data[2:0];
        REG_PING_ENABLE: cfg.ping_enable      <= cfg_data[0];
        REG_MAX_RETRIES: cfg.max_retries      <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

endmodule

// ----- hw/rtl/ldcr_deframer.sv -----
// Byte window, header and response matching, and packet checksum tracking.
// Depends on ldcr_pkg for item, result and configuration types.
module ldcr_deframer
  import ldcr_pkg::*;
#(
  parameter int unsigned WINDOW_BYTES   = 4,
  parameter int unsigned PACKET_BYTES   = 64,
  parameter int unsigned RESPONSE_WORDS = 4
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           accept,
  input  ldcr_item_t     item,
  input  ldcr_cfg_t      cfg,
  output ldcr_defr_out_t dout
);

  localparam int unsigned FILL_W   = $clog2(WINDOW_BYTES + 1);
  localparam int unsigned POS_W    = $clog2(PACKET_BYTES + 1);
  localparam int unsigned SLOT_W   = $clog2(CHECK_LEN);
  localparam int unsigned WIN_BITS = 8 * WINDOW_BYTES;
  localparam int unsigned FOLD_END = PACKET_BYTES - CHECK_LEN;
  localparam int unsigned HDR_SLOT = (WINDOW_BYTES == FOLD_END) ? 0 : WINDOW_BYTES;

  logic [7:0]        window [WINDOW_BYTES];
  logic [FILL_W-1:0] window_fill;
  logic              in_packet;
  logic [POS_W-1:0]  packet_position;
  logic [7:0]        check_bytes [CHECK_LEN];
  logic [SLOT_W-1:0] check_slot;
  logic              check_mismatch;

  logic [7:0]          win_new [WINDOW_BYTES];
  logic [WIN_BITS-1:0] win_flat;
  logic                win_full;
  logic                hdr_hit;
  logic [2:0]          resp_lim;
  logic                resp_any;
  logic [1:0]          resp_idx;
  logic [7:0]          hdr_check [CHECK_LEN];
  logic [7:0]          pkt_check [CHECK_LEN];
  logic                fold_phase;
  logic [POS_W-1:0]    pos_inc;
  logic                pkt_done;
  logic [SLOT_W-1:0]   slot_inc;
  logic                mismatch_new;
  logic                byte_op;

  assign byte_op = accept && (item.op == OP_BYTE);

  always_comb begin
    for (int i = 0; i < WINDOW_BYTES; i++) begin
      win_new[i] = (window_fill == FILL_W'(i)) ? item.rx_byte : window[i];
      win_flat[8*i +: 8] = win_new[i];
    end
  end

  assign win_full = (window_fill == FILL_W'(WINDOW_BYTES - 1));
  assign hdr_hit  = (win_flat == cfg.header_word[WIN_BITS-1:0]);
  assign resp_lim = (cfg.response_count > 3'(RESPONSE_WORDS)) ?
                    3'(RESPONSE_WORDS) : cfg.response_count;

  always_comb begin
    resp_any = 1'b0;
    resp_idx = 2'd0;
    for (int r = RESPONSE_WORDS - 1; r >= 0; r--) begin
      if ((3'(r) < resp_lim) && (win_flat == cfg.response_word[r][WIN_BITS-1:0])) begin
        resp_any = 1'b1;
        resp_idx = 2'(r);
      end
    end
  end

  // The header bytes fold into a cleared checksum at positions up to and including the window size.
  always_comb begin
    for (int j = 0; j < CHECK_LEN; j++) begin
      hdr_check[j] = 8'd0;
    end
    for (int i = 0; i < WINDOW_BYTES; i++) begin
      hdr_check[i]     = hdr_check[i] ^ win_new[i];
      hdr_check[i + 1] = hdr_check[i + 1] ^ nibble_swap(win_new[i]);
    end
  end

  assign fold_phase   = (packet_position < POS_W'(FOLD_END));
  assign pos_inc      = packet_position + POS_W'(1);
  assign pkt_done     = (pos_inc == POS_W'(PACKET_BYTES));
  assign slot_inc     = (check_slot == SLOT_W'(CHECK_LEN - 1)) ?
                        SLOT_W'(0) : check_slot + SLOT_W'(1);
  assign mismatch_new = check_mismatch ||
                        (!fold_phase && (check_bytes[check_slot] != item.rx_byte));

  always_comb begin
    for (int j = 0; j < CHECK_LEN; j++) begin
      pkt_check[j] = check_bytes[j]
                   ^ ((check_slot == SLOT_W'(j)) ? item.rx_byte : 8'd0)
                   ^ ((slot_inc == SLOT_W'(j)) ? nibble_swap(item.rx_byte) : 8'd0);
    end
  end

  always_comb begin
    dout = '0;
    if (byte_op) begin
      if (in_packet) begin
        dout.res_valid      = 1'b1;
        dout.res.byte_value = item.rx_byte;
        dout.res.last       = 1'b1;
        if (!pkt_done) begin
          dout.res.kind = KIND_PKT_BYTE;
        end else if (mismatch_new) begin
          dout.res.kind = KIND_PKT_BAD;
        end else begin
          dout.res.kind = KIND_PKT_GOOD;
        end
      end else if (win_full && !hdr_hit) begin
        dout.res_valid = 1'b1;
        dout.res.last  = 1'b1;
        if (resp_any) begin
          dout.res.kind           = KIND_RESPONSE;
          dout.res.response_index = resp_idx;
          dout.resp_hit           = 1'b1;
        end else begin
          dout.res.kind         = KIND_UNKNOWN;
          dout.res.window_bytes = 64'(win_flat);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_fill     <= '0;
      in_packet       <= 1'b0;
      packet_position <= '0;
      check_slot      <= '0;
      check_mismatch  <= 1'b0;
      for (int j = 0; j < CHECK_LEN; j++) begin
        check_bytes[j] <= 8'd0;
      end
    end else if (byte_op) begin
      if (in_packet) begin
        if (fold_phase) begin
          check_bytes <= pkt_check;
        end
        check_mismatch <= mismatch_new;
        check_slot     <= (pos_inc == POS_W'(FOLD_END)) ? SLOT_W'(0) : slot_inc;
        if (pkt_done) begin
          in_packet       <= 1'b0;
          packet_position <= '0;
        end else begin
          packet_position <= pos_inc;
        end
      end else if (!win_full) begin
        window_fill <= FILL_W'(window_fill + 1'b1);
      end else if (hdr_hit) begin
        in_packet       <= 1'b1;
        packet_position <= POS_W'(WINDOW_BYTES);
        check_bytes     <= hdr_check;
        check_mismatch  <= 1'b0;
        check_slot      <= SLOT_W'(HDR_SLOT);
        window_fill     <= '0;
      end else if (resp_any) begin
        window_fill <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (byte_op && !in_packet) begin
      if (win_full && !hdr_hit && !resp_any) begin
        for (int i = 0; i < WINDOW_BYTES - 1; i++) begin
          window[i] <= win_new[i + 1];
        end
      end else begin
        window <= win_new;
      end
    end
  end

endmodule

// ----- hw/rtl/ldcr_cmd_retry.sv -----
// Pending command tracking: issue, resend on ticks, retry limit and pings.
// Depends on ldcr_pkg for item, result and configuration types.
module ldcr_cmd_retry
  import ldcr_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          accept,
  input  ldcr_item_t    item,
  input  ldcr_cfg_t     cfg,
  input  logic          resp_clear,
  output ldcr_cmd_out_t cout
);

  logic       command_pending;
  logic [7:0] pending_code;
  logic [7:0] retry_count;

  logic tick;
  logic issue;
  logic fail;
  logic ping;

  assign tick  = accept && (item.op == OP_TICK) && item.port_open;
  assign issue = accept && (item.op == OP_CMD);
  assign fail  = command_pending && (retry_count >= cfg.max_retries);
  assign ping  = cfg.ping_enable && !fail;

  always_comb begin
    cout = '0;
    if (tick) begin
      if (command_pending) begin
        cout.res0.kind        = fail ? KIND_CMD_FAILED : KIND_SEND_CMD;
        cout.res0.command_out = pending_code;
        if (ping) begin
          cout.res1.kind = KIND_PING;
          cout.res1.last = 1'b1;
          cout.res_count = 2'd2;
        end else begin
          cout.res0.last = 1'b1;
          cout.res_count = 2'd1;
        end
      end else if (ping) begin
        cout.res0.kind = KIND_PING;
        cout.res0.last = 1'b1;
        cout.res_count = 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      command_pending <= 1'b0;
      pending_code    <= 8'd0;
      retry_count     <= 8'd0;
    end else if (resp_clear || (tick && fail)) begin
      command_pending <= 1'b0;
      pending_code    <= 8'd0;
      retry_count     <= 8'd0;
    end else if (tick && command_pending) begin
      retry_count <= retry_count + 8'd1;
    end else if (issue) begin
      if (!command_pending || (item.command_code != pending_code)) begin
        retry_count <= 8'd0;
      end
      command_pending <= 1'b1;
      pending_code    <= item.command_code;
    end
  end

endmodule

// ----- hw/rtl/ldcr_result_fifo.sv -----
// Small result queue that takes up to two results per cycle and sends one when the results channel is ready.
// Depends on ldcr_pkg and the ldcr_chan_if channel interface.
module ldcr_result_fifo
  import ldcr_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic [1:0]   push_count,
  input  ldcr_result_t push0,
  input  ldcr_result_t push1,
  output logic         has_room,
  ldcr_chan_if.source  results
);

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  ldcr_result_t     entries [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             pop;

  assign results.valid   = (count != '0);
  assign results.payload = entries[rd_ptr];
  assign pop             = results.valid && results.ready;
  assign has_room        = (count <= CNT_W'(QUEUE_DEPTH - 2));

  always_ff @(posedge clk) begin
    if (push_count != 2'd0) begin
      entries[wr_ptr] <= push0;
    end
    if (push_count == 2'd2) begin
      entries[PTR_W'(wr_ptr + 1'b1)] <= push1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= PTR_W'(wr_ptr + PTR_W'(push_count));
      rd_ptr <= PTR_W'(rd_ptr + PTR_W'(pop));
      count  <= CNT_W'(count + CNT_W'(push_count) - CNT_W'(pop));
    end
  end

endmodule

// ----- hw/rtl/link_deframer_with_command_retry_unit.sv -----
// Top level of the link deframer with command retry.
// Depends on ldcr_pkg, ldcr_chan_if, ldcr_cfg_regs, ldcr_deframer,
// ldcr_cmd_retry and ldcr_result_fifo.
//
// One input transaction is taken per clock cycle while input ready is high;
// its results enter a four-entry result queue at the edge that accepts it
// and are offered one per cycle while the results channel is ready, from the
// following cycle. Input ready stays high while the queue has two free
// entries and reset is low, so input items stall only when the results side
// backs up; a tick that both resends a command and sends a ping yields two
// results and consumes two queue entries. Packet bytes stream out as they
// arrive and no memory needs clearing after reset.
module link_deframer_with_command_retry_unit
  import ldcr_pkg::*;
#(
  parameter int unsigned WINDOW_BYTES   = 4,
  parameter int unsigned PACKET_BYTES   = 64,
  parameter int unsigned RESPONSE_WORDS = 4
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write_en,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [63:0]            cfg_data,
  ldcr_chan_if.sink              items,
  ldcr_chan_if.source            results
);

  ldcr_cfg_t      cfg;
  ldcr_defr_out_t defr_out;
  ldcr_cmd_out_t  cmd_out;
  logic           accept;
  logic           has_room;
  logic [1:0]     push_count;
  ldcr_result_t   push0;
  ldcr_result_t   push1;

  assign items.ready = has_room && !rst;
  assign accept      = items.valid && items.ready;

  ldcr_cfg_regs u_cfg_regs (
    .clk          (clk),
    .rst          (rst),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .cfg          (cfg)
  );

  ldcr_deframer #(
    .WINDOW_BYTES   (WINDOW_BYTES),
    .PACKET_BYTES   (PACKET_BYTES),
    .RESPONSE_WORDS (RESPONSE_WORDS)
  ) u_deframer (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .item   (items.payload),
    .cfg    (cfg),
    .dout   (defr_out)
  );

  ldcr_cmd_retry u_cmd_retry (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .item       (items.payload),
    .cfg        (cfg),
    .resp_clear (defr_out.resp_hit),
    .cout       (cmd_out)
  );

  always_comb begin
    if (defr_out.res_valid) begin
      push_count = 2'd1;
      push0      = defr_out.res;
      push1      = cmd_out.res1;
    end else begin
      push_count = cmd_out.res_count;
      push0      = cmd_out.res0;
      push1      = cmd_out.res1;
    end
  end

  ldcr_result_fifo u_result_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_count (push_count),
    .push0      (push0),
    .push1      (push1),
    .has_room   (has_room),
    .results    (results)
  );

`ifndef SYNTHESIS
  a_single_source: assert property (@(posedge clk) disable iff (rst)
    !(defr_out.res_valid && (cmd_out.res_count != 2'd0)))
    else $error("deframer and command unit produced results for the same transaction");

  a_cmd_silent: assert property (@(posedge clk) disable iff (rst)
    (accept && (items.payload.op == OP_CMD)) |-> (push_count == 2'd0))
    else $error("command issue produced a result");

  a_push_visible: assert property (@(posedge clk) disable iff (rst)
    (push_count != 2'd0) |=> results.valid)
    else $error("queued result not offered on the results channel");

  a_resp_hit_kind: assert property (@(posedge clk) disable iff (rst)
    defr_out.resp_hit |-> (defr_out.res_valid && (defr_out.res.kind == KIND_RESPONSE)))
    else $error("response match cleared the command without a response result");
`endif

endmodule
